FILE: rtl/core/lvbg_pkg.sv
// Shared constants, codes and types of the Laplacian-variance blur gate.
`default_nettype none
package lvbg_pkg;
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 13;
   localparam int THR_W      = 24;
   localparam int SCORE_W    = 24;
   localparam int VERDICT_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int LAP_W      = 11;
   localparam int LAP_MAG_W  = 10;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_FRAC_BITS  = 4;

   localparam int DEFAULT_REJECT   = 40;
   localparam int DEFAULT_MARGINAL = 120;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REJECT_THR   = 2'd2;

   localparam logic [VERDICT_W-1:0] VERDICT_REJECT   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_MARGINAL = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_OK       = 2'd2;

   typedef struct packed {
      logic start;
      logic ack;
   } score_ctl_type;

   // BT.601 luma, integer weights summing to 256
   function automatic logic [PIX_W-1:0] luma_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
      logic [15:0] acc;
      acc = 16'(16'd77 * 16'(r)) + 16'(16'd150 * 16'(g)) + 16'(16'd29 * 16'(b)) + 16'd128;
      return acc[15:8];
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/lvbg_ifs.sv
// Channel interfaces: pixel requests, score responses and register writes.
`default_nettype none
interface lvbg_req_if;
   logic                          valid;
   logic                          ready;
   logic [lvbg_pkg::PIX_W-1:0]    pixel_red;
   logic [lvbg_pkg::PIX_W-1:0]    pixel_green;
   logic [lvbg_pkg::PIX_W-1:0]    pixel_blue;
   modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface lvbg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lvbg_pkg::SCORE_W-1:0]    blur_score;
   logic [lvbg_pkg::VERDICT_W-1:0]  verdict;
   modport source (output valid, blur_score, verdict, input ready);
   modport sink   (input valid, blur_score, verdict, output ready);
endinterface

interface lvbg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [lvbg_pkg::CSR_IDX_W-1:0]   index;
   logic [lvbg_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lvbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lvbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/core/lvbg_score.sv
// Per-frame variance unit: shift-add products, then restoring division.
`default_nettype none
module lvbg_score #(
   parameter int CNT_W = 24,
   parameter int FRAC  = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lvbg_pkg::score_ctl_type       ctl,
   input  wire logic signed [CNT_W+10:0]      lap_sum,
   input  wire logic        [CNT_W+19:0]      lap_sq_sum,
   input  wire logic        [CNT_W-1:0]       lap_count,
   output logic                               done,
   output logic        [lvbg_pkg::SCORE_W-1:0] score
);
   import lvbg_pkg::*;

   localparam int SUM_W = CNT_W + 11;
   localparam int SQ_W  = CNT_W + 20;
   localparam int MAG_W = CNT_W + 10;
   localparam int MP_W  = MAG_W;
   localparam int PR_W  = SQ_W + MP_W;
   localparam int NUM_W = PR_W + FRAC;
   localparam int CW    = $clog2(MP_W + 1);

   typedef enum logic [5:0] {
      SC_IDLE = 6'b000001,
      SC_MULA = 6'b000010,
      SC_MULB = 6'b000100,
      SC_MULD = 6'b001000,
      SC_DIV  = 6'b010000,
      SC_DONE = 6'b100000
   } sc_state_type;

   sc_state_type       state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [PR_W-1:0]    mc_ff, mc_in;
   logic [MP_W-1:0]    mp_ff, mp_in;
   logic [PR_W-1:0]    acc_ff, acc_in;
   logic [PR_W-1:0]    a_ff, a_in;
   logic [PR_W-1:0]    b_ff, b_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   dsh_ff, dsh_in;
   logic [SCORE_W-1:0] q_ff, q_in;

   logic [SUM_W-1:0]   sum_neg;
   logic [PR_W-1:0]    prod;
   logic               mul_last;
   logic [NUM_W-1:0]   num;
   logic [NUM_W-1:0]   dfull;
   logic [NUM_W-1:0]   dnext;

   always_comb begin
      sum_neg  = -lap_sum;
      prod     = acc_ff + (mp_ff[0] ? mc_ff : '0);
      mul_last = (cnt_ff == CW'(MP_W - 1));
      num      = NUM_W'(a_ff - b_ff) << FRAC;
      dfull    = NUM_W'(prod) << SCORE_W;
      dnext    = dsh_ff >> 1;

      state_in = state_ff;
      mag_in   = mag_ff;
      n_in     = n_ff;
      mc_in    = mc_ff << 1;
      mp_in    = mp_ff >> 1;
      acc_in   = prod;
      a_in     = a_ff;
      b_in     = b_ff;
      cnt_in   = cnt_ff + CW'(1);
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;

      case (state_ff)
         SC_IDLE: begin
            cnt_in = '0;
            if (ctl.start) begin
               mag_in   = lap_sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : lap_sum[MAG_W-1:0];
               n_in     = lap_count;
               mc_in    = PR_W'(lap_sq_sum);
               mp_in    = MP_W'(lap_count);
               acc_in   = '0;
               state_in = SC_MULA;
            end
         end
         SC_MULA: begin
            if (mul_last) begin
               a_in     = prod;
               mc_in    = PR_W'(mag_ff);
               mp_in    = mag_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = SC_MULB;
            end
         end
         SC_MULB: begin
            if (mul_last) begin
               b_in     = prod;
               mc_in    = PR_W'(n_ff);
               mp_in    = MP_W'(n_ff);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = SC_MULD;
            end
         end
         SC_MULD: begin
            if (mul_last) begin
               cnt_in = '0;
               rem_in = num;
               dsh_in = dfull;
               if (n_ff == '0 || a_ff <= b_ff) begin
                  q_in     = '0;
                  state_in = SC_DONE;
               end else if (num >= dfull) begin
                  q_in     = '1;
                  state_in = SC_DONE;
               end else begin
                  q_in     = '0;
                  state_in = SC_DIV;
               end
            end
         end
         SC_DIV: begin
            dsh_in = dnext;
            if (rem_ff >= dnext) begin
               rem_in = rem_ff - dnext;
               q_in   = {q_ff[SCORE_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[SCORE_W-2:0], 1'b0};
            end
            if (cnt_ff == CW'(SCORE_W - 1)) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            if (ctl.ack) begin
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      n_ff   <= n_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done  = (state_ff == SC_DONE);
   assign score = q_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == SC_IDLE)
      else $error("score unit started while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == SC_DIV |-> rem_ff < dsh_ff)
      else $error("division remainder out of range");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_DONE && !ctl.ack) |=> (state_ff == SC_DONE && $stable(q_ff)))
      else $error("score dropped before acknowledge");
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SC_MULA || state_ff == SC_MULB || state_ff == SC_MULD)
         |-> cnt_ff < CW'(MP_W))
      else $error("multiplier step count overrun");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/laplacian_variance_blur_gate_unit.sv
// Top level: luma, line stores, Laplacian accumulation, frame score output.
// Pixels enter in raster order; a new pixel is taken only after the last one is
// processed (line-store read issued at the transfer, data used in the next cycle),
// and each row end adds a prime step to prefetch the first entry of the row above.
// After the last pixel of a frame the score unit runs three bit-serial products
// of CNT_W+10 steps each and, unless the quotient is zero or saturates, a 24-step
// division, during which no pixel is taken. The result waits in an output register;
// the next frame may start while it is still pending. Line stores hold no reset value.
`default_nettype none
module laplacian_variance_blur_gate_unit #(
   parameter int MAX_WIDTH           = lvbg_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT          = lvbg_pkg::DEF_MAX_HEIGHT,
   parameter int SCORE_FRACTION_BITS = lvbg_pkg::DEF_FRAC_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   lvbg_req_if.sink   req_ch,
   lvbg_rsp_if.source rsp_ch,
   lvbg_csr_if.sink   csr_ch
);
   import lvbg_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YAW   = $clog2(MAX_HEIGHT);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2((MAX_WIDTH - 2) * (MAX_HEIGHT - 2) + 1);
   localparam int SUM_W = CNT_W + 11;
   localparam int SQ_W  = CNT_W + 20;

   typedef enum logic [5:0] {
      T_IDLE  = 6'b000001,
      T_CALC  = 6'b000010,
      T_PRIME = 6'b000100,
      T_DRAIN = 6'b001000,
      T_START = 6'b010000,
      T_WAIT  = 6'b100000
   } top_state_type;

   top_state_type           state_ff, state_in;
   logic [DIM_W-1:0]        cfg_width_ff, cfg_height_ff;
   logic [THR_W-1:0]        cfg_thr_ff;
   logic [AW-1:0]           x_ff, x_in;
   logic [YAW-1:0]          y_ff, y_in;
   logic                    bank_ff, bank_in;
   logic                    prime_ff;
   logic [PIX_W-1:0]        luma_ff;
   logic [PIX_W-1:0]        win_m1_ff, win_0_ff;
   logic [LAP_W-1:0]        lap_ff;
   logic                    lap_valid_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    rsp_valid_ff;
   logic [SCORE_W-1:0]      rsp_score_ff;
   logic [VERDICT_W-1:0]    rsp_verdict_ff;

   logic [XW-1:0]           w_eff;
   logic [YW-1:0]           h_eff;
   logic                    row_end, frame_end, interior;
   logic [AW-1:0]           x_next_addr;
   logic [AW-1:0]           raddr0, raddr1;
   logic [PIX_W-1:0]        rdata0, rdata1;
   logic [PIX_W-1:0]        older_rd, recent_rd;
   logic [11:0]             lap_wide;
   logic [LAP_W-1:0]        lap_neg;
   logic [LAP_MAG_W-1:0]    lap_mag;
   logic [2*LAP_MAG_W-1:0]  lap_sq;
   logic                    req_fire, emit;
   logic [31:0]             rej_lim, mar_lim;
   logic [VERDICT_W-1:0]    verdict_in;
   logic                    score_done;
   logic [SCORE_W-1:0]      score_val;
   score_ctl_type           sc_ctl;

   // effective frame size: zero acts as one, large values saturate
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = XW'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = YW'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(cfg_height_ff);
      end
   end

   assign row_end   = (32'(x_ff) + 32'd1) >= 32'(w_eff);
   assign frame_end = (32'(y_ff) + 32'd1) >= 32'(h_eff);
   assign interior  = (32'(y_ff) >= 32'd2) && (x_ff != '0) &&
                      ((32'(x_ff) + 32'd2) <= 32'(w_eff));

   assign req_ch.ready = (state_ff == T_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // older row lives in bank bank_ff, the row above in the other bank
   assign x_next_addr = x_ff + AW'(1);
   always_comb begin
      raddr0 = x_ff;
      raddr1 = x_ff;
      if (bank_ff) begin
         raddr0 = (state_ff == T_PRIME) ? '0 : x_next_addr;
      end else begin
         raddr1 = (state_ff == T_PRIME) ? '0 : x_next_addr;
      end
   end

   lvbg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock (clock),
      .we    ((state_ff == T_CALC) && !bank_ff),
      .waddr (x_ff),
      .wdata (luma_ff),
      .raddr (raddr0),
      .rdata (rdata0)
   );

   lvbg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock (clock),
      .we    ((state_ff == T_CALC) && bank_ff),
      .waddr (x_ff),
      .wdata (luma_ff),
      .raddr (raddr1),
      .rdata (rdata1)
   );

   assign older_rd  = bank_ff ? rdata1 : rdata0;
   assign recent_rd = bank_ff ? rdata0 : rdata1;
   assign lap_wide  = 12'(older_rd) + 12'(luma_ff) + 12'(win_m1_ff) + 12'(recent_rd)
                      - {2'b00, win_0_ff, 2'b00};
   assign lap_neg   = -lap_ff;
   assign lap_mag   = lap_ff[LAP_W-1] ? lap_neg[LAP_MAG_W-1:0] : lap_ff[LAP_MAG_W-1:0];
   assign lap_sq    = lap_mag * lap_mag;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      bank_in  = bank_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               state_in = T_CALC;
            end
         end
         T_CALC: begin
            if (row_end) begin
               x_in    = '0;
               bank_in = !bank_ff;
               if (frame_end) begin
                  y_in     = '0;
                  state_in = T_DRAIN;
               end else begin
                  y_in     = y_ff + YAW'(1);
                  state_in = T_PRIME;
               end
            end else begin
               x_in     = x_ff + AW'(1);
               state_in = T_IDLE;
            end
         end
         T_PRIME: state_in = T_IDLE;
         T_DRAIN: state_in = T_START;
         T_START: state_in = T_WAIT;
         T_WAIT: begin
            if (emit) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   assign emit       = (state_ff == T_WAIT) && score_done && (!rsp_valid_ff || rsp_ch.ready);
   assign sc_ctl     = '{start: (state_ff == T_START), ack: emit};

   always_comb begin
      if (cfg_thr_ff != '0) begin
         rej_lim = 32'(cfg_thr_ff);
         mar_lim = 32'(cfg_thr_ff) * 32'd3;
      end else begin
         rej_lim = 32'(DEFAULT_REJECT) << SCORE_FRACTION_BITS;
         mar_lim = 32'(DEFAULT_MARGINAL) << SCORE_FRACTION_BITS;
      end
      if (32'(score_val) < rej_lim) begin
         verdict_in = VERDICT_REJECT;
      end else if (32'(score_val) < mar_lim) begin
         verdict_in = VERDICT_MARGINAL;
      end else begin
         verdict_in = VERDICT_OK;
      end
   end

   lvbg_score #(.CNT_W(CNT_W), .FRAC(SCORE_FRACTION_BITS)) u_score (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sc_ctl),
      .lap_sum    (sum_ff),
      .lap_sq_sum (sq_ff),
      .lap_count  (cnt_ff),
      .done       (score_done),
      .score      (score_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         cfg_width_ff  <= RESET_WIDTH;
         cfg_height_ff <= RESET_HEIGHT;
         cfg_thr_ff    <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         bank_ff       <= 1'b0;
         prime_ff      <= 1'b0;
         lap_valid_ff  <= 1'b0;
         sum_ff        <= '0;
         sq_ff         <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         bank_ff      <= bank_in;
         prime_ff     <= (state_ff == T_PRIME);
         lap_valid_ff <= (state_ff == T_CALC) && interior;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_ch.data[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_ch.data[DIM_W-1:0];
               CSR_REJECT_THR:   cfg_thr_ff    <= csr_ch.data[THR_W-1:0];
               default: ;
            endcase
         end
         // accumulators are snapshotted by the score unit on start
         if (state_ff == T_START) begin
            sum_ff <= '0;
            sq_ff  <= '0;
            cnt_ff <= '0;
         end else if (lap_valid_ff) begin
            sum_ff <= sum_ff + {{(SUM_W-LAP_W){lap_ff[LAP_W-1]}}, lap_ff};
            sq_ff  <= sq_ff + SQ_W'(lap_sq);
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         luma_ff <= luma_of(req_ch.pixel_red, req_ch.pixel_green, req_ch.pixel_blue);
      end
      if (state_ff == T_CALC) begin
         lap_ff    <= lap_wide[LAP_W-1:0];
         win_m1_ff <= win_0_ff;
         win_0_ff  <= recent_rd;
      end else if (prime_ff) begin
         win_0_ff  <= recent_rd;
      end
      if (emit) begin
         rsp_score_ff   <= score_val;
         rsp_verdict_ff <= verdict_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.blur_score = rsp_score_ff;
   assign rsp_ch.verdict    = rsp_verdict_ff;
endmodule
`default_nettype wire

FILE: verif/tb_laplacian_variance_blur_gate_unit.sv
// Self-checking testbench: random and patterned RGB frames against an internal blur-score predictor.
`default_nettype none
module tb_laplacian_variance_blur_gate_unit;
   import lvbg_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct {
      logic [SCORE_W-1:0]   score;
      logic [VERDICT_W-1:0] verdict;
   } score_type;

   localparam int FRAME_MAX = 4096;

   logic clock;
   logic reset;

   lvbg_req_if req_ch ();
   lvbg_rsp_if rsp_ch ();
   lvbg_csr_if csr_ch ();

   laplacian_variance_blur_gate_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pixel_type pixel_q[$];
   score_type score_q[$];
   int     errors;
   int     pixels_queued;
   int     pixels_taken;
   int     send_gap;
   int     recv_gap;
   int     recv_hold;
   bit     burst_mode;

   // predictor state
   logic [PIX_W-1:0]  row_store[2][FRAME_MAX];
   bit                older_sel;
   int                col_pos;
   int                row_pos;
   longint            lap_sum;
   longint unsigned   lap_sq_sum;
   longint unsigned   lap_count;
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   logic [THR_W-1:0]  thr_reg;

   function automatic int eff_dim(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      return (v > FRAME_MAX) ? FRAME_MAX : int'(v);
   endfunction

   function automatic logic [SCORE_W-1:0] variance_q4(longint s, longint unsigned s2,
                                                      longint unsigned n);
      logic [127:0]    a;
      logic [127:0]    b;
      logic [127:0]    q;
      longint unsigned mag;
      if (n == 0) return '0;
      mag = (s < 0) ? longint'(-s) : s;
      a = 128'(s2) * 128'(n);
      b = 128'(mag) * 128'(mag);
      if (a <= b) return '0;
      q = ((a - b) << DEF_FRAC_BITS) / (128'(n) * 128'(n));
      return (q > 128'hFFFFFF) ? 24'hFFFFFF : q[SCORE_W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic predict_pixel(pixel_type p);
      int     w;
      int     h;
      int     luma;
      int     lap;
      score_type s;
      longint unsigned rej;
      longint unsigned mar;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      luma = (77 * p.red + 150 * p.green + 29 * p.blue + 128) >> 8;
      // center sits one row up; this pixel is its south neighbor
      if (row_pos >= 2 && col_pos >= 1 && col_pos + 2 <= w) begin
         lap = row_store[older_sel][col_pos] + luma
             + row_store[!older_sel][col_pos-1] + row_store[!older_sel][col_pos+1]
             - 4 * row_store[!older_sel][col_pos];
         lap_sum += lap;
         lap_sq_sum += longint'(lap * lap);
         lap_count++;
      end
      row_store[older_sel][col_pos] = luma[PIX_W-1:0];
      if (col_pos + 1 >= w) begin
         older_sel = !older_sel;
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            s.score = variance_q4(lap_sum, lap_sq_sum, lap_count);
            rej = (thr_reg != 0) ? thr_reg : (DEFAULT_REJECT << DEF_FRAC_BITS);
            mar = (thr_reg != 0) ? 3 * longint'(thr_reg) : (DEFAULT_MARGINAL << DEF_FRAC_BITS);
            s.verdict = (s.score < rej) ? VERDICT_REJECT
                      : (s.score < mar) ? VERDICT_MARGINAL : VERDICT_OK;
            score_q.push_back(s);
            row_pos = 0;
            lap_sum = 0;
            lap_sq_sum = 0;
            lap_count = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // pixel sender
   always @(posedge clock) begin
      pixel_type p;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (send_gap > 0 || pixel_q.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            p = pixel_q.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.pixel_red   <= p.red;
            req_ch.pixel_green <= p.green;
            req_ch.pixel_blue  <= p.blue;
            send_gap = pick_gap();
         end
      end
   end

   // predict on every pixel transfer
   always @(posedge clock) begin
      pixel_type p;
      if (!reset && req_ch.valid && req_ch.ready) begin
         p.red   = req_ch.pixel_red;
         p.green = req_ch.pixel_green;
         p.blue  = req_ch.pixel_blue;
         predict_pixel(p);
         pixels_taken++;
      end
   end

   // result receiver with random stalls and an optional long hold-off
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else if (recv_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_hold--;
      end else if (recv_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_gap--;
      end else begin
         rsp_ch.ready <= 1'b1;
         r = $urandom_range(0, 99);
         if (!burst_mode && r < 30) recv_gap = (r < 4) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
      end
   end

   // result checker
   always @(posedge clock) begin
      score_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (score_q.size() == 0) begin
            $display("%0t: unexpected result score=%0d verdict=%0d", $time,
                     rsp_ch.blur_score, rsp_ch.verdict);
            errors++;
         end else begin
            e = score_q.pop_front();
            if (rsp_ch.blur_score !== e.score) begin
               $display("%0t: blur_score expected %0d actual %0d", $time, e.score,
                        rsp_ch.blur_score);
               errors++;
            end
            if (rsp_ch.verdict !== e.verdict) begin
               $display("%0t: verdict expected %0d actual %0d", $time, e.verdict,
                        rsp_ch.verdict);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT: height_reg = value[DIM_W-1:0];
         CSR_REJECT_THR:   thr_reg = value[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(int w, int h, int thr);
      csr_write(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_REJECT_THR, CSR_DATA_W'(thr));
   endtask

   // kind: 0 random, 1 flat, 2 black/white checker, 3 sparse bright spots
   task automatic queue_frame(int kind);
      int     w;
      int     h;
      pixel_type p;
      logic [PIX_W-1:0] v;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      v = PIX_W'($urandom);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            case (kind)
               1: begin p.red = v; p.green = v; p.blue = v; end
               2: begin
                  p.red = ((x + y) % 2) ? 8'hFF : 8'h00;
                  p.green = p.red;
                  p.blue = p.red;
               end
               3: begin
                  p.red   = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'h00;
                  p.green = p.red;
                  p.blue  = PIX_W'($urandom);
               end
               default: begin
                  p.red   = PIX_W'($urandom);
                  p.green = PIX_W'($urandom);
                  p.blue  = PIX_W'($urandom);
               end
            endcase
            pixel_q.push_back(p);
            pixels_queued++;
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pixels_taken != pixels_queued || score_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_thr();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return 24'hFFFFFF;
         3: return $urandom_range(1, 4000);
         4: return $urandom_range(0, 24'hFFFFFF);
         default: return $urandom_range(100, 30000);
      endcase
   endfunction

   initial begin
      int w;
      int h;
      errors = 0;
      pixels_queued = 0;
      pixels_taken = 0;
      recv_hold = 0;
      burst_mode = 1'b0;
      older_sel = 1'b0;
      col_pos = 0;
      row_pos = 0;
      lap_sum = 0;
      lap_sq_sum = 0;
      lap_count = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      thr_reg = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest interior, zero dims, narrow frame, default thresholds
      configure(3, 3, 0);
      queue_frame(2);
      queue_frame(1);
      wait_idle();
      configure(0, 0, 1);
      queue_frame(0);
      wait_idle();
      configure(2, 5, 24'hFFFFFF);
      queue_frame(0);
      wait_idle();

      // output stalled long while frames keep coming
      configure(3, 3, pick_thr());
      recv_hold = 800;
      repeat (6) queue_frame(0);
      wait_idle();

      while (pixels_queued < 1300) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         burst_mode = ($urandom_range(0, 4) == 0);
         configure(w, h, pick_thr());
         repeat ($urandom_range(1, 4)) queue_frame($urandom_range(0, 3));
         wait_idle();
      end
      burst_mode = 1'b0;

      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("laplacian_variance_blur_gate_unit: match");
      end else begin
         $display("laplacian_variance_blur_gate_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("laplacian_variance_blur_gate_unit: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/lvbg_pkg.sv
rtl/core/lvbg_ifs.sv
rtl/core/lvbg_ram.sv
rtl/core/lvbg_score.sv
rtl/core/laplacian_variance_blur_gate_unit.sv
verif/tb_laplacian_variance_blur_gate_unit.sv
